### rtl/core/save_marker_signature_scanner_core_assert.svh
// Assertion macros for the save marker scanner checker.
`ifndef SAVE_MARKER_SIGNATURE_SCANNER_CORE_ASSERT_SVH
`define SAVE_MARKER_SIGNATURE_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, muted while arst_n is low.
`define SSSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sssc checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, muted while arst_n is low.
`define SSSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sssc checker: next-cycle property failed");

`endif

### rtl/core/sssc_pkg.sv
`timescale 1ns / 1ps

package sssc_pkg;

	localparam int MARKER_COUNT = 6;
	localparam int WINDOW_DEPTH = 10;
	localparam int MARKER_MAX   = WINDOW_DEPTH + 1;
	localparam int KIND_W       = 3;

	typedef logic [7:0]              byte_t;
	typedef logic [KIND_W-1:0]       kind_t;
	typedef logic [MARKER_COUNT-1:0] flags_t;
	typedef byte_t [MARKER_COUNT-1:0] marker_bytes_t;

	// Save-type codes
	localparam kind_t KIND_NONE       = 3'd0;
	localparam kind_t KIND_EEPROM_4K  = 3'd1;
	localparam kind_t KIND_EEPROM_64K = 3'd2;
	localparam kind_t KIND_SRAM       = 3'd3;
	localparam kind_t KIND_FLASH_1M   = 3'd4;
	localparam kind_t KIND_FLASH_512K = 3'd5;

	// Marker bit positions
	localparam int MK_EEP_4K    = 0;
	localparam int MK_EEP_64K   = 1;
	localparam int MK_SRAM_V    = 2;
	localparam int MK_FL_1M     = 3;
	localparam int MK_FL_512K   = 4;
	localparam int MK_FLASH_V   = 5;

	// Marker text stored last character first; unused tail is zero
	localparam byte_t MARKER_REV [MARKER_COUNT][MARKER_MAX] = '{
		'{"1", "1", "1", "V", "_", "M", "O", "R", "P", "E", "E"},
		'{"V", "_", "M", "O", "R", "P", "E", "E", 8'h00, 8'h00, 8'h00},
		'{"V", "_", "M", "A", "R", "S", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"V", "_", "M", "1", "H", "S", "A", "L", "F", 8'h00, 8'h00},
		'{"V", "_", "2", "1", "5", "H", "S", "A", "L", "F", 8'h00},
		'{"V", "_", "H", "S", "A", "L", "F", 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam int MARKER_LEN [MARKER_COUNT] = '{11, 8, 6, 9, 10, 7};

	// Control handed from the top level to every window cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Lowest set flag wins; both flash 512k markers share one code
	function automatic kind_t kind_of(input flags_t flags);
		kind_t k;
		k = KIND_NONE;
		if (flags[MK_EEP_4K])
			k = KIND_EEPROM_4K;
		else if (flags[MK_EEP_64K])
			k = KIND_EEPROM_64K;
		else if (flags[MK_SRAM_V])
			k = KIND_SRAM;
		else if (flags[MK_FL_1M])
			k = KIND_FLASH_1M;
		else if (flags[MK_FL_512K] || flags[MK_FLASH_V])
			k = KIND_FLASH_512K;
		return k;
	endfunction

endpackage

### rtl/core/sssc_image_if.sv
`timescale 1ns / 1ps

interface sssc_image_if;
	logic            valid;
	logic            ready;
	sssc_pkg::byte_t image_byte;
	logic            end_of_image;

	modport source (output valid, output image_byte, output end_of_image, input ready);
	modport sink   (input valid, input image_byte, input end_of_image, output ready);
endinterface

### rtl/core/sssc_result_if.sv
`timescale 1ns / 1ps

interface sssc_result_if;
	logic             valid;
	logic             ready;
	sssc_pkg::kind_t  save_kind;
	sssc_pkg::flags_t markers_seen;

	modport source (output valid, output save_kind, output markers_seen, input ready);
	modport sink   (input valid, input save_kind, input markers_seen, output ready);
endinterface

### rtl/core/save_marker_signature_scanner_core.sv
`timescale 1ns / 1ps

// Save marker scanner.
// The image channel takes one byte per transaction, with end_of_image set on
// the final byte. Six marker strings are searched for anywhere in the image;
// on the final byte one transaction leaves on the result channel carrying the
// save-type code (priority by marker order) and the found-marker vector.
// Non-final bytes give no result.
// Throughput: one byte per cycle while the skid stage is empty; the ten-cell
// window shifts and compares every byte in the cycle it is accepted.
// Result: captured in the output register, or in the skid stage if that is stalled.
// After the final byte the window and the flags are cleared, so the next
// image may start as soon as image ready is high.
// Stall: an output register and a skid stage hold up to two results; image
// ready drops only while the skid stage is occupied.
// Reset (arst_n low): window zero, flags zero, no result pending.
module save_marker_signature_scanner_core (
	input  logic         clk,
	input  logic         arst_n,
	sssc_image_if.sink   image,
	sssc_result_if.source result
);

	localparam int NC = sssc_pkg::WINDOW_DEPTH;
	localparam int MC = sssc_pkg::MARKER_COUNT;

	logic                 acc;
	logic                 produce;
	logic                 take;
	sssc_pkg::cell_ctrl_t ctrl;
	sssc_pkg::flags_t     hit_chain [NC+1];
	sssc_pkg::byte_t      byte_chain [NC+1];
	sssc_pkg::flags_t     flags_q;
	sssc_pkg::flags_t     flags_next;
	sssc_pkg::kind_t      res_kind;

	logic                 out_valid_q;
	sssc_pkg::kind_t      out_kind_q;
	sssc_pkg::flags_t     out_seen_q;
	logic                 skid_valid_q;
	sssc_pkg::kind_t      skid_kind_q;
	sssc_pkg::flags_t     skid_seen_q;

	assign image.ready = !skid_valid_q;
	assign acc         = image.valid && image.ready;
	assign produce     = acc && image.end_of_image;
	assign take        = out_valid_q && result.ready;

	assign ctrl.shift = acc && !image.end_of_image;
	assign ctrl.clear = produce;

	// Head of the chain: current byte against each marker's last character
	always_comb begin
		for (int m = 0; m < MC; m++) begin
			hit_chain[0][m] = (image.image_byte == sssc_pkg::MARKER_REV[m][0]);
		end
	end
	assign byte_chain[0] = image.image_byte;

	// Window cells, newest byte first
	for (genvar i = 0; i < NC; i++) begin : g_cell
		sssc_pkg::marker_bytes_t cell_expect;
		sssc_pkg::flags_t        cell_care;

		for (genvar m = 0; m < MC; m++) begin : g_mk
			assign cell_expect[m] = sssc_pkg::MARKER_REV[m][i+1];
			assign cell_care[m]   = (i + 1 < sssc_pkg::MARKER_LEN[m]);
		end

		sssc_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.byte_prev    (byte_chain[i]),
			.byte_next    (byte_chain[i+1]),
			.expect_bytes (cell_expect),
			.care         (cell_care),
			.hit_prev     (hit_chain[i]),
			.hit_next     (hit_chain[i+1])
		);
	end

	assign flags_next = flags_q | hit_chain[NC];
	assign res_kind   = sssc_pkg::kind_of(flags_next);

	// Sticky marker flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (acc) begin
			flags_q <= image.end_of_image ? '0 : flags_next;
		end
	end

	// Output register and skid stage: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (produce && (!out_valid_q || take)) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= skid_valid_q;
			end
			if (produce && out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else if (take) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	// Output register and skid stage: payload
	always_ff @(posedge clk) begin
		if (produce && (!out_valid_q || take)) begin
			out_kind_q <= res_kind;
			out_seen_q <= flags_next;
		end else if (take && skid_valid_q) begin
			out_kind_q <= skid_kind_q;
			out_seen_q <= skid_seen_q;
		end
		if (produce && out_valid_q && !take) begin
			skid_kind_q <= res_kind;
			skid_seen_q <= flags_next;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.save_kind    = out_kind_q;
	assign result.markers_seen = out_seen_q;

endmodule

### rtl/core/sssc_cell.sv
`timescale 1ns / 1ps

// One window position: holds a byte, passes it on, and extends the match chain
module sssc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sssc_pkg::cell_ctrl_t       ctrl,
	input  sssc_pkg::byte_t            byte_prev,
	output sssc_pkg::byte_t            byte_next,
	input  sssc_pkg::marker_bytes_t    expect_bytes,
	input  sssc_pkg::flags_t           care,
	input  sssc_pkg::flags_t           hit_prev,
	output sssc_pkg::flags_t           hit_next
);

	sssc_pkg::byte_t byte_q;
	sssc_pkg::flags_t own_hit;

	// Window byte: cleared at image end, shifted on every other transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= byte_prev;
		end
	end

	// Per-marker compare; positions beyond a marker's length always pass
	always_comb begin
		for (int m = 0; m < sssc_pkg::MARKER_COUNT; m++) begin
			own_hit[m] = !care[m] || (byte_q == expect_bytes[m]);
		end
	end

	assign hit_next  = hit_prev & own_hit;
	assign byte_next = byte_q;

endmodule

### rtl/core/sssc_checker.sv
`timescale 1ns / 1ps
`include "save_marker_signature_scanner_core_assert.svh"

// Port-level checks on the save marker scanner
module sssc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             image_valid,
	input logic             image_ready,
	input logic             end_of_image,
	input logic             result_valid,
	input logic             result_ready,
	input sssc_pkg::kind_t  save_kind,
	input sssc_pkg::flags_t markers_seen
);

	logic                                               final_acc;
	logic                                               res_stall;
	logic                                               no_marks;
	logic                                               top_mark;
	logic [sssc_pkg::KIND_W+sssc_pkg::MARKER_COUNT-1:0] payload;

	assign final_acc = image_valid && image_ready && end_of_image;
	assign res_stall = result_valid && !result_ready;
	assign no_marks  = (markers_seen == '0);
	assign top_mark  = result_valid && markers_seen[sssc_pkg::MK_EEP_4K];
	assign payload   = {save_kind, markers_seen};

	// A stalled result holds its payload
	`SSSC_ASSERT_NEXT(a_result_hold, res_stall, result_valid && $stable(payload))

	// A fresh result only follows a final-byte transaction
	`SSSC_ASSERT_NOW(a_result_cause, $rose(result_valid), $past(final_acc))

	// No markers means no save type, and the reverse
	`SSSC_ASSERT_NOW(a_kind_none, result_valid, no_marks == (save_kind == sssc_pkg::KIND_NONE))

	// The long eeprom marker takes top priority
	`SSSC_ASSERT_NOW(a_kind_top, top_mark, save_kind == sssc_pkg::KIND_EEPROM_4K)

endmodule

bind save_marker_signature_scanner_core sssc_checker u_sssc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.image_valid  (image.valid),
	.image_ready  (image.ready),
	.end_of_image (image.end_of_image),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.save_kind    (result.save_kind),
	.markers_seen (result.markers_seen)
);
